// ----- sv/tte_pkg.sv -----
// Shared constants, types and helpers for the text terminal engine.
package tte_pkg;

  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 40;
  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int ROW_W = 5;
  localparam int COL_W = 6;
  localparam int CHAR_W = 8;
  localparam int COLOR_W = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_DIGIT0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT9 = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CH_DOWN = 8'h42;
  localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h43;
  localparam logic [CHAR_W-1:0] CH_LEFT = 8'h44;
  localparam logic [CHAR_W-1:0] CH_HOME = 8'h48;
  localparam logic [CHAR_W-1:0] CH_CLR_SCREEN = 8'h4A;
  localparam logic [CHAR_W-1:0] CH_CLR_LINE = 8'h4B;
  localparam logic [COLOR_W-1:0] WHITE = 6'h3F;

  typedef struct packed {
    logic              cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  rc;
    logic              esc_start;
    logic              in_range;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;
    logic               in_escape;
  } result_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    int a;
    a = int'(row) * SCREEN_COLS + int'(col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// ----- sv/tte_front.sv -----
// Input side: classifies incoming beats and queues them for the executor.
module tte_front import tte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              cmd,
  input  logic [CHAR_W-1:0] char_in,
  input  logic [ROW_W-1:0]  read_row,
  input  logic [COL_W-1:0]  read_col,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_take
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_take;
  item_t             incoming;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_take = q_take && q_valid;

  always_comb begin
    incoming.cmd = cmd;
    incoming.ch = char_in;
    incoming.rr = read_row;
    incoming.rc = read_col;
    incoming.esc_start = (char_in == CH_ESC);
    incoming.in_range = (int'(read_row) < SCREEN_ROWS) && (int'(read_col) < SCREEN_COLS);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_take) begin
        count <= count + 1'b1;
      end else if (do_take && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/tte_back.sv -----
// Executor: screen store, row colors, cursor, escape parser and result register.
module tte_back import tte_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    copy_row_color,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_take,
  output logic    out_valid,
  output result_t out_data,
  input  logic    pop
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;

  logic [CHAR_W-1:0]  mem [CELLS];
  logic [CHAR_W-1:0]  rdata;
  logic [ADDR_W-1:0]  raddr;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [CHAR_W-1:0]  wdata;

  logic [2:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   end_addr;
  logic               sv;
  logic [ADDR_W-1:0]  paddr;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [2:0]         esc_count;
  logic [CHAR_W-1:0]  esc0;
  logic [CHAR_W-1:0]  esc1;
  logic [COLOR_W-1:0] colors [SCREEN_ROWS];
  logic [ROW_W-1:0]   rd_row;
  logic               rd_in_range;
  logic [ROW_W-1:0]   color_raddr;
  logic [COLOR_W-1:0] color_rd;

  logic               start;
  logic [2:0]         ec0;
  logic [2:0]         cnt1;
  logic [2:0]         esc_count_next;
  logic [ROW_W-1:0]   cur_row_next;
  logic [COL_W-1:0]   cur_col_next;
  logic               char_we;
  logic [COL_W-1:0]   char_col;
  logic [CHAR_W-1:0]  char_val;
  logic               nl;
  logic               color_copy;
  logic               scroll_go;
  logic               blank_go;
  logic               blank_screen;
  logic               esc0_we;
  logic               esc1_we;
  logic [6:0]         amount;
  logic [7:0]         sum;
  logic [COL_W-1:0]   tab_col;
  logic               is_digit;
  logic               load_out;
  result_t            out_next;

  assign start = (state == S_IDLE) && q_valid && (!out_valid || pop);
  assign q_take = start;
  assign color_raddr = (state == S_READ) ? rd_row : cur_row;
  assign color_rd = colors[color_raddr];

  always_comb begin
    ec0 = (esc_count > 3'd4) ? 3'd0 : esc_count;
    cnt1 = ec0 + 3'd1;
    esc_count_next = ec0;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    char_we = 1'b0;
    char_col = cur_col;
    char_val = CH_SPACE;
    nl = 1'b0;
    blank_go = 1'b0;
    blank_screen = 1'b0;
    esc0_we = 1'b0;
    esc1_we = 1'b0;
    amount = 7'd1;
    sum = '0;
    tab_col = {cur_col[COL_W-1:2], 2'b00};
    is_digit = (q_item.ch >= CH_DIGIT0) && (q_item.ch <= CH_DIGIT9);
    if (q_item.esc_start) begin
      esc_count_next = 3'd1;
    end else if (ec0 != 3'd0) begin
      if (ec0 < 3'd2) begin
        esc_count_next = (q_item.ch == CH_LBRACKET) ? 3'd2 : 3'd0;
      end else begin
        esc0_we = (ec0 == 3'd2);
        esc1_we = (ec0 == 3'd3);
        if (is_digit) begin
          esc_count_next = cnt1;
        end else begin
          esc_count_next = 3'd0;
          if (cnt1 == 3'd5) begin
            amount = 7'(esc0[3:0]) * 7'd10 + 7'(esc1[3:0]);
          end else if (cnt1 == 3'd4) begin
            amount = 7'(esc0[3:0]);
          end
          unique case (q_item.ch)
            CH_UP: begin
              cur_row_next = (8'(amount) < 8'(cur_row)) ? ROW_W'(8'(cur_row) - 8'(amount)) : '0;
            end
            CH_DOWN: begin
              sum = 8'(cur_row) + 8'(amount);
              cur_row_next = (sum < 8'(SCREEN_ROWS - 1)) ? ROW_W'(sum)
                                                          : ROW_W'(SCREEN_ROWS - 1);
            end
            CH_RIGHT: begin
              sum = 8'(cur_col) + 8'(amount);
              cur_col_next = (sum < 8'(SCREEN_COLS - 1)) ? COL_W'(sum)
                                                          : COL_W'(SCREEN_COLS - 1);
            end
            CH_LEFT: begin
              cur_col_next = (8'(amount) < 8'(cur_col)) ? COL_W'(8'(cur_col) - 8'(amount)) : '0;
            end
            CH_HOME: begin
              cur_row_next = '0;
              cur_col_next = '0;
            end
            CH_CLR_SCREEN: begin
              blank_go = 1'b1;
              blank_screen = 1'b1;
            end
            CH_CLR_LINE: begin
              blank_go = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
    end else begin
      unique case (q_item.ch)
        CH_BS: begin
          if (cur_col != '0) begin
            cur_col_next = cur_col - 1'b1;
            char_col = cur_col - 1'b1;
            char_we = 1'b1;
          end
        end
        CH_DEL: begin
          char_we = 1'b1;
          if (int'(cur_col) < SCREEN_COLS - 1) begin
            cur_col_next = cur_col + 1'b1;
          end
        end
        CH_TAB: begin
          cur_col_next = (int'(tab_col) + 5 < SCREEN_COLS) ? tab_col + COL_W'(4)
                                                           : COL_W'(SCREEN_COLS - 1);
        end
        CH_LF: begin
          nl = 1'b1;
        end
        CH_CR: begin
          cur_col_next = '0;
        end
        default: begin
          if (q_item.ch >= CH_SPACE) begin
            char_we = 1'b1;
            char_val = q_item.ch;
            if (int'(cur_col) + 1 >= SCREEN_COLS) begin
              nl = 1'b1;
            end else begin
              cur_col_next = cur_col + 1'b1;
            end
          end
        end
      endcase
    end
    color_copy = 1'b0;
    scroll_go = 1'b0;
    if (nl) begin
      cur_col_next = '0;
      if (int'(cur_row) < SCREEN_ROWS - 1) begin
        cur_row_next = cur_row + 1'b1;
        color_copy = copy_row_color;
      end else begin
        scroll_go = 1'b1;
      end
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = cell_addr(cur_row, char_col);
    wdata = char_val;
    raddr = cell_addr(q_item.rr, q_item.rc);
    unique case (state)
      S_CLEAR, S_BLANK: begin
        we = 1'b1;
        waddr = cnt[ADDR_W-1:0];
        wdata = CH_SPACE;
      end
      S_SCROLL: begin
        we = sv;
        waddr = paddr;
        wdata = rdata;
        raddr = cnt[ADDR_W-1:0];
      end
      S_IDLE: begin
        we = start && !q_item.cmd && char_we;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    load_out = 1'b0;
    out_next.cursor_row = cur_row;
    out_next.cursor_col = cur_col;
    out_next.cell_char = '0;
    out_next.cell_color = '0;
    out_next.in_escape = (esc_count != 3'd0);
    unique case (state)
      S_IDLE: begin
        if (start && !q_item.cmd && !scroll_go && !blank_go) begin
          load_out = 1'b1;
          out_next.cursor_row = cur_row_next;
          out_next.cursor_col = cur_col_next;
          out_next.in_escape = (esc_count_next != 3'd0);
        end
      end
      S_READ: begin
        load_out = 1'b1;
        out_next.cell_char = rd_in_range ? rdata : '0;
        out_next.cell_color = rd_in_range ? color_rd : '0;
      end
      S_BLANK: begin
        load_out = (cnt == end_addr);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      end_addr <= CNT_W'(CELLS - 1);
      sv <= 1'b0;
      cur_row <= '0;
      cur_col <= '0;
      esc_count <= '0;
      out_valid <= 1'b0;
      for (int r = 0; r < SCREEN_ROWS; r++) begin
        colors[r] <= WHITE;
      end
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (cnt == CNT_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (q_item.cmd) begin
              rd_row <= q_item.rr;
              rd_in_range <= q_item.in_range;
              state <= S_READ;
            end else begin
              cur_row <= cur_row_next;
              cur_col <= cur_col_next;
              esc_count <= esc_count_next;
              if (esc0_we) begin
                esc0 <= q_item.ch;
              end
              if (esc1_we) begin
                esc1 <= q_item.ch;
              end
              if (color_copy) begin
                colors[cur_row + 1'b1] <= color_rd;
              end
              if (scroll_go) begin
                for (int r = 0; r < SCREEN_ROWS - 1; r++) begin
                  colors[r] <= colors[r + 1];
                end
                if (!copy_row_color) begin
                  colors[SCREEN_ROWS - 1] <= WHITE;
                end
                cnt <= CNT_W'(SCREEN_COLS);
                sv <= 1'b0;
                state <= S_SCROLL;
              end else if (blank_go) begin
                cnt <= CNT_W'(cell_addr(cur_row, cur_col));
                end_addr <= blank_screen ? CNT_W'(CELLS - 1)
                                         : CNT_W'(cell_addr(cur_row, '0)) +
                                           CNT_W'(SCREEN_COLS - 1);
                state <= S_BLANK;
              end
            end
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        S_SCROLL: begin
          if (cnt < CNT_W'(CELLS)) begin
            sv <= 1'b1;
            paddr <= ADDR_W'(cnt - CNT_W'(SCREEN_COLS));
            cnt <= cnt + 1'b1;
          end else begin
            sv <= 1'b0;
            if (!sv) begin
              cnt <= CNT_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
              end_addr <= CNT_W'(CELLS - 1);
              state <= S_BLANK;
            end
          end
        end
        S_BLANK: begin
          if (cnt == end_addr) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/ansi_text_terminal_engine.sv -----
// Top level of the text terminal engine.
// Input queue: drive cmd, char_in, read_row, read_col with push; a beat is taken
//   on a rising edge with push high and full low. cmd 0 feeds a terminal byte,
//   cmd 1 reads one screen cell and the color of its row.
// Result queue: while empty is low the oldest result is on cursor_row,
//   cursor_col, cell_char, cell_color and in_escape; pop high takes it.
// Every input beat gives exactly one result beat, in order.
// Flow: a byte that only moves the cursor or writes a cell passes the input
//   queue and the result register; a cell read adds the registered store read;
//   a scroll copies one cell per cycle through the screen store, then blanks
//   one row; clears to end of line or screen blank one cell after another.
// copy_row_color is written through copy_row_color_we / copy_row_color_wdata
//   and must change only while the engine is idle.
// Reset (rst, synchronous): cursor home, colors white, both queues empty; then a
//   clearing pass fills all CELLS cells of the screen store with spaces, during
//   which input beats are queued but not executed.
// When the receiver holds pop low the result stays on the ports; a two-entry
//   input queue keeps taking beats until it fills.
module ansi_text_terminal_engine import tte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  logic [CHAR_W-1:0]  char_in,
  input  logic [ROW_W-1:0]   read_row,
  input  logic [COL_W-1:0]   read_col,
  output logic               empty,
  input  logic               pop,
  output logic [ROW_W-1:0]   cursor_row,
  output logic [COL_W-1:0]   cursor_col,
  output logic [CHAR_W-1:0]  cell_char,
  output logic [COLOR_W-1:0] cell_color,
  output logic               in_escape,
  input  logic               copy_row_color_we,
  input  logic               copy_row_color_wdata
);

  logic    copy_row_color;
  logic    q_valid;
  item_t   q_item;
  logic    q_take;
  logic    out_valid;
  result_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      copy_row_color <= 1'b1;
    end else if (copy_row_color_we) begin
      copy_row_color <= copy_row_color_wdata;
    end
  end

  tte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .cmd      (cmd),
    .char_in  (char_in),
    .read_row (read_row),
    .read_col (read_col),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  tte_back u_back (
    .clk            (clk),
    .rst            (rst),
    .copy_row_color (copy_row_color),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_take         (q_take),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .pop            (pop)
  );

  assign empty = !out_valid;
  assign cursor_row = out_data.cursor_row;
  assign cursor_col = out_data.cursor_col;
  assign cell_char = out_data.cell_char;
  assign cell_color = out_data.cell_color;
  assign in_escape = out_data.in_escape;

endmodule

// ----- sv/tte_checker.sv -----
// Port-level checks for the text terminal engine, bound to the top level.
module tte_checker import tte_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [ROW_W-1:0]   cursor_row,
  input logic [COL_W-1:0]   cursor_col,
  input logic [CHAR_W-1:0]  cell_char
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result beat dropped");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(cursor_row) && $stable(cursor_col) && $stable(cell_char)))
    else $error("waiting result beat changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((int'(cursor_row) < SCREEN_ROWS) && (int'(cursor_col) < SCREEN_COLS)))
    else $error("cursor outside screen");

endmodule

bind ansi_text_terminal_engine tte_checker u_tte_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .cursor_row (cursor_row),
  .cursor_col (cursor_col),
  .cell_char  (cell_char)
);
